[rtl/tsq_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package tsq_pkg;

    // Item operation codes
    typedef enum logic {
        OP_TICK  = 1'b0,
        OP_WRITE = 1'b1
    } op_t;

    // Configuration register indexes
    typedef enum logic {
        CFG_SONG_LENGTH = 1'b0,
        CFG_NOTE_TICKS  = 1'b1
    } cfg_reg_t;

    localparam int unsigned CHANNELS   = 4;
    localparam int unsigned PERIOD_W   = 16;
    localparam int unsigned POS_W      = 8;
    localparam int unsigned LENGTH_W   = 9;
    localparam int unsigned TICKS_W    = 16;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [LENGTH_W-1:0] SONG_LENGTH_RESET = 9'd256;
    localparam logic [TICKS_W-1:0]  NOTE_TICKS_RESET  = 16'h3d09;

    // One song entry: channel periods and the gates of channels 1 and 2
    typedef struct packed {
        logic [CHANNELS-1:0][PERIOD_W-1:0] period;
        logic [1:0]                        gate;
    } entry_t;

    // One result item
    typedef struct packed {
        logic             level;
        logic [1:0]       sel;
        logic [POS_W-1:0] pos;
    } result_t;

endpackage

`default_nettype wire

[rtl/tsq_song_mem.sv]
`timescale 1ns / 1ps
`default_nettype none

module tsq_song_mem #(
    parameter int unsigned SONG_DEPTH = 256
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           we,
    input  wire logic [tsq_pkg::POS_W-1:0]      waddr,
    input  wire tsq_pkg::entry_t                wentry,
    input  wire logic [tsq_pkg::POS_W-1:0]      raddr,
    output tsq_pkg::entry_t                     rentry
);

    localparam int unsigned ADDR_W = (SONG_DEPTH > 1) ? $clog2(SONG_DEPTH) : 1;

    tsq_pkg::entry_t mem [SONG_DEPTH];
    tsq_pkg::entry_t rdata_reg;
    logic            rok_reg;
    logic            wok;
    logic            rok;
    logic            fwd;

    // Drop writes and reads beyond the table depth
    assign wok = (32'(waddr) < 32'(SONG_DEPTH));
    assign rok = (32'(raddr) < 32'(SONG_DEPTH));
    assign fwd = we && wok && (waddr == raddr);

    // Write port
    always_ff @(posedge clk)
    begin
        if (we && wok)
        begin
            mem[ADDR_W'(waddr)] <= wentry;
        end
    end

    // Read port, forward a write to the same entry
    always_ff @(posedge clk)
    begin
        if (fwd)
        begin
            rdata_reg <= wentry;
        end
        else if (rok)
        begin
            rdata_reg <= mem[ADDR_W'(raddr)];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rok_reg <= 1'b0;
        end
        else
        begin
            rok_reg <= rok;
        end
    end

    // Out-of-range position reads as zero
    assign rentry = rok_reg ? rdata_reg : '0;

endmodule

`default_nettype wire

[rtl/tsq_tone_core.sv]
`timescale 1ns / 1ps
`default_nettype none

module tsq_tone_core (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               tick,
    input  wire logic                               cfg_we,
    input  wire logic                               cfg_sel,
    input  wire logic [tsq_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  wire tsq_pkg::entry_t                    entry,
    output logic [tsq_pkg::POS_W-1:0]               pos_next,
    output tsq_pkg::result_t                        result
);

    logic [tsq_pkg::CHANNELS-1:0][tsq_pkg::PERIOD_W-1:0] phase_reg;
    logic [tsq_pkg::CHANNELS-1:0][tsq_pkg::PERIOD_W-1:0] phase_next;
    logic [tsq_pkg::CHANNELS-1:0]                        levels_reg;
    logic [tsq_pkg::CHANNELS-1:0]                        levels_next;
    logic [tsq_pkg::CHANNELS-1:0]                        gated;
    logic [tsq_pkg::POS_W-1:0]                           pos_reg;
    logic [tsq_pkg::TICKS_W-1:0]                         dur_reg;
    logic [tsq_pkg::TICKS_W-1:0]                         dur_next;
    logic [1:0]                                          mod3_reg;
    logic [1:0]                                          mod3_next;
    logic [tsq_pkg::LENGTH_W-1:0]                        song_length_reg;
    logic [tsq_pkg::TICKS_W-1:0]                         note_ticks_reg;
    logic [tsq_pkg::LENGTH_W-1:0]                        pos_inc;
    logic [1:0]                                          sel;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            song_length_reg <= tsq_pkg::SONG_LENGTH_RESET;
            note_ticks_reg  <= tsq_pkg::NOTE_TICKS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_sel)
                tsq_pkg::CFG_SONG_LENGTH: song_length_reg <= cfg_wdata[tsq_pkg::LENGTH_W-1:0];
                tsq_pkg::CFG_NOTE_TICKS:  note_ticks_reg  <= cfg_wdata;
                default:                  note_ticks_reg  <= note_ticks_reg;
            endcase
        end
    end

    // Gate channels 1 and 2 by stored bits, 3 and 4 by a nonzero period
    assign gated = {|entry.period[3], |entry.period[2], entry.gate};

    // Advance phases, duration and song position
    always_comb
    begin
        phase_next  = phase_reg;
        levels_next = levels_reg;
        dur_next    = dur_reg;
        mod3_next   = mod3_reg;
        pos_next    = pos_reg;
        pos_inc     = {1'b0, pos_reg} + 9'd1;
        if (tick)
        begin
            for (int ch = 0; ch < tsq_pkg::CHANNELS; ch++)
            begin
                if (phase_reg[ch] > {1'b0, entry.period[ch][tsq_pkg::PERIOD_W-1:1]})
                begin
                    phase_next[ch] = '0;
                    if (gated[ch])
                    begin
                        levels_next[ch] = !levels_reg[ch];
                    end
                end
                else
                begin
                    phase_next[ch] = phase_reg[ch] + 16'd1;
                end
            end
            if (dur_reg < note_ticks_reg)
            begin
                dur_next  = dur_reg + 16'd1;
                mod3_next = (mod3_reg == 2'd2) ? 2'd0 : mod3_reg + 2'd1;
            end
            else
            begin
                dur_next  = '0;
                mod3_next = 2'd0;
                if (pos_inc >= song_length_reg || pos_inc[tsq_pkg::POS_W])
                begin
                    pos_next = '0;
                end
                else
                begin
                    pos_next = pos_inc[tsq_pkg::POS_W-1:0];
                end
            end
        end
    end

    // Pick the channel from the updated duration
    always_comb
    begin
        if (dur_next[1:0] == 2'd0)
        begin
            sel = 2'd0;
        end
        else if (mod3_next == 2'd0)
        begin
            sel = 2'd1;
        end
        else if (!dur_next[0])
        begin
            sel = 2'd2;
        end
        else
        begin
            sel = 2'd3;
        end
    end

    assign result.level = levels_next[sel];
    assign result.sel   = sel;
    assign result.pos   = pos_next;

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= '0;
            levels_reg <= '0;
            pos_reg    <= '0;
            dur_reg    <= '0;
            mod3_reg   <= 2'd0;
        end
        else
        begin
            phase_reg  <= phase_next;
            levels_reg <= levels_next;
            pos_reg    <= pos_next;
            dur_reg    <= dur_next;
            mod3_reg   <= mod3_next;
        end
    end

`ifndef ASSERT_OFF
    // Residue counter never leaves 0..2
    a_mod3_range: assert property (@(posedge clk) disable iff (!rst_n)
        mod3_reg != 2'd3)
        else $error("duration residue out of range");

    // Position moves only on a duration restart
    a_pos_on_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(pos_reg) |-> (dur_reg == '0 && mod3_reg == 2'd0))
        else $error("song position moved without duration restart");
`endif

endmodule

`default_nettype wire

[rtl/tsq_out_buf.sv]
`timescale 1ns / 1ps
`default_nettype none

module tsq_out_buf (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire tsq_pkg::result_t push_data,
    input  wire logic             out_stall,
    output logic                  full,
    output logic                  out_valid,
    output tsq_pkg::result_t      out_data
);

    logic             main_valid_reg;
    logic             skid_valid_reg;
    tsq_pkg::result_t main_reg;
    tsq_pkg::result_t skid_reg;
    logic             pop;

    assign pop       = main_valid_reg && !out_stall;
    assign full      = skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    // Valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (main_valid_reg && !pop)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                main_valid_reg <= 1'b1;
            end
        end
        else if (pop)
        begin
            main_valid_reg <= 1'b0;
        end
    end

    // Payload: refill main from skid, else load the new item
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                main_reg <= skid_reg;
            end
        end
        else if (push)
        begin
            if (main_valid_reg && !pop)
            begin
                skid_reg <= push_data;
            end
            else
            begin
                main_reg <= push_data;
            end
        end
    end

`ifndef ASSERT_OFF
    // Skid holds an item only behind a full main stage
    a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid full while main empty");

    // Skid fills only when main was stalled
    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(main_valid_reg && out_stall && push))
        else $error("skid filled without a stall");
`endif

endmodule

`default_nettype wire

[rtl/four_channel_square_tone_sequencer_top.sv]
`timescale 1ns / 1ps
`default_nettype none

// Four-channel square-wave tone sequencer. Items on the input channel either
// store one song entry (operation 1: four period words and two gate bits at
// entry_index) or advance the tone generators by one tick (operation 0). Each
// tick yields one result item with the selected channel's level, the channel
// number and the song position after the tick; a write yields none. One item
// is taken every clock cycle as long as the output side keeps up: the song
// table is a synchronous memory read ahead at the next position,
// with a write to that same entry forwarded into the read register, so a
// tick never waits on the table. Results pass through a two-deep output
// buffer, so the input stalls only after two results sit unclaimed. The
// configuration port (index 0 song length, 1 note ticks) is always ready and
// must be written only while the block is idle. No clearing pass is run after
// reset; a tick at a song entry that was never written gives undefined levels.

module four_channel_square_tone_sequencer_top #(
    parameter int unsigned SONG_DEPTH = 256
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic                               operation,
    input  wire logic [tsq_pkg::POS_W-1:0]          entry_index,
    input  wire logic [tsq_pkg::PERIOD_W-1:0]       period_one,
    input  wire logic [tsq_pkg::PERIOD_W-1:0]       period_two,
    input  wire logic [tsq_pkg::PERIOD_W-1:0]       period_three,
    input  wire logic [tsq_pkg::PERIOD_W-1:0]       period_four,
    input  wire logic                               gate_one,
    input  wire logic                               gate_two,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic                                    audio_level,
    output logic [1:0]                              selected_channel,
    output logic [tsq_pkg::POS_W-1:0]               note_position,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic                               cfg_index,
    input  wire logic [tsq_pkg::CFG_DATA_W-1:0]     cfg_data
);

    logic                      in_accept;
    logic                      tick;
    logic                      wr;
    logic                      buf_full;
    logic [tsq_pkg::POS_W-1:0] pos_next;
    tsq_pkg::entry_t           wentry;
    tsq_pkg::entry_t           rentry;
    tsq_pkg::result_t          result;
    tsq_pkg::result_t          out_data;

    // Decode the accepted item
    assign in_stall  = buf_full;
    assign in_accept = in_valid && !in_stall;
    assign tick      = in_accept && (operation == tsq_pkg::OP_TICK);
    assign wr        = in_accept && (operation == tsq_pkg::OP_WRITE);
    assign cfg_ready = 1'b1;

    assign wentry.period = {period_four, period_three, period_two, period_one};
    assign wentry.gate   = {gate_two, gate_one};

    tsq_song_mem #(
        .SONG_DEPTH (SONG_DEPTH)
    ) u_mem (
        .clk    (clk),
        .rst_n  (rst_n),
        .we     (wr),
        .waddr  (entry_index),
        .wentry (wentry),
        .raddr  (pos_next),
        .rentry (rentry)
    );

    tsq_tone_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .tick      (tick),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_sel   (cfg_index),
        .cfg_wdata (cfg_data),
        .entry     (rentry),
        .pos_next  (pos_next),
        .result    (result)
    );

    tsq_out_buf u_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (tick),
        .push_data (result),
        .out_stall (out_stall),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

    assign audio_level      = out_data.level;
    assign selected_channel = out_data.sel;
    assign note_position    = out_data.pos;

endmodule

`default_nettype wire

[bench/four_channel_square_tone_sequencer_top_tb.sv]
`timescale 1ns / 1ps

module four_channel_square_tone_sequencer_top_tb;

    localparam int unsigned RUN_LIMIT   = 200000;
    localparam int unsigned HOLD_CYCLES = 80;
    localparam int unsigned DRAIN_PAD   = 8;
    localparam int unsigned END_PAD     = 20;
    localparam int unsigned NUM_PHASES  = 7;
    localparam int unsigned TABLE_DEPTH = 256;

    localparam tsq_pkg::op_t ROW_WR = tsq_pkg::OP_WRITE;
    localparam tsq_pkg::op_t ROW_TK = tsq_pkg::OP_TICK;

    // One input item as offered on the item channel
    typedef struct packed {
        tsq_pkg::op_t                                        op;
        logic [tsq_pkg::POS_W-1:0]                           idx;
        logic [tsq_pkg::CHANNELS-1:0][tsq_pkg::PERIOD_W-1:0] per;
        logic                                                g1;
        logic                                                g2;
    } tone_item_t;

    // One row of the directed table
    typedef struct {
        tone_item_t       item;
        bit               typed;
        tsq_pkg::result_t want;
    } stim_row_t;

    logic                             clk = 1'b0;
    logic                             rst_n;
    logic                             in_valid;
    logic                             in_stall;
    logic                             operation;
    logic [tsq_pkg::POS_W-1:0]        entry_index;
    logic [tsq_pkg::PERIOD_W-1:0]     period_one;
    logic [tsq_pkg::PERIOD_W-1:0]     period_two;
    logic [tsq_pkg::PERIOD_W-1:0]     period_three;
    logic [tsq_pkg::PERIOD_W-1:0]     period_four;
    logic                             gate_one;
    logic                             gate_two;
    logic                             out_valid;
    logic                             out_stall;
    logic                             audio_level;
    logic [1:0]                       selected_channel;
    logic [tsq_pkg::POS_W-1:0]        note_position;
    logic                             cfg_valid;
    logic                             cfg_ready;
    logic                             cfg_index;
    logic [tsq_pkg::CFG_DATA_W-1:0]   cfg_data;

    // Predicted block state
    tsq_pkg::entry_t                  song_table [TABLE_DEPTH];
    bit                               entry_written [TABLE_DEPTH];
    logic [tsq_pkg::PERIOD_W-1:0]     chan_phase [tsq_pkg::CHANNELS];
    logic [tsq_pkg::CHANNELS-1:0]     chan_level;
    logic [tsq_pkg::POS_W-1:0]        song_pos;
    logic [tsq_pkg::TICKS_W-1:0]      dur_count;
    logic [tsq_pkg::LENGTH_W-1:0]     cfg_song_len;
    logic [tsq_pkg::TICKS_W-1:0]      cfg_note_ticks;

    tsq_pkg::result_t                 tone_results_due [$];
    stim_row_t                        directed_rows [$];

    int unsigned           sender_idle_pct = 23;
    int unsigned           recv_idle_pct   = 56;
    bit                    hold_request    = 1'b0;
    int unsigned           cycle_count     = 0;
    int unsigned           fail_count      = 0;
    int unsigned           results_checked = 0;
    int unsigned           ticks_sent      = 0;
    int unsigned           writes_sent     = 0;

    four_channel_square_tone_sequencer_top u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .operation        (operation),
        .entry_index      (entry_index),
        .period_one       (period_one),
        .period_two       (period_two),
        .period_three     (period_three),
        .period_four      (period_four),
        .gate_one         (gate_one),
        .gate_two         (gate_two),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .audio_level      (audio_level),
        .selected_channel (selected_channel),
        .note_position    (note_position),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Bound the run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Advance the tone state by one item; report the result item it causes
    task automatic advance_song(input tone_item_t it, output bit made,
                                output tsq_pkg::result_t res);
        tsq_pkg::entry_t              cur;
        logic [tsq_pkg::CHANNELS-1:0] gated;
        logic [tsq_pkg::LENGTH_W-1:0] nxt;
        logic [1:0]                   chan;
        int                           c;
        made = 1'b0;
        res  = '0;
        if (it.op == tsq_pkg::OP_WRITE)
        begin
            song_table[it.idx].period = it.per;
            song_table[it.idx].gate   = {it.g2, it.g1};
            entry_written[it.idx]     = 1'b1;
            writes_sent++;
        end
        else
        begin
            cur   = song_table[song_pos];
            // channels 3 and 4 are gated by a nonzero period
            gated = {cur.period[3] != '0, cur.period[2] != '0, cur.gate[1], cur.gate[0]};
            for (c = 0; c < tsq_pkg::CHANNELS; c++)
            begin
                if (chan_phase[c] > (cur.period[c] >> 1))
                begin
                    if (gated[c])
                        chan_level[c] = ~chan_level[c];
                    chan_phase[c] = '0;
                end
                else
                begin
                    chan_phase[c] = chan_phase[c] + 16'd1;
                end
            end

            // step the note duration, wrap the position at the song length or the table end
            if (dur_count < cfg_note_ticks)
            begin
                dur_count = dur_count + 16'd1;
            end
            else
            begin
                nxt = {1'b0, song_pos} + 9'd1;
                if (nxt >= cfg_song_len || nxt >= 9'd256)
                    nxt = '0;
                song_pos  = nxt[tsq_pkg::POS_W-1:0];
                dur_count = '0;
            end

            // multiplex the output channel by the updated duration
            if (dur_count % 4 == 0)
                chan = 2'd0;
            else if (dur_count % 3 == 0)
                chan = 2'd1;
            else if (dur_count % 2 == 0)
                chan = 2'd2;
            else
                chan = 2'd3;

            res.level = chan_level[chan];
            res.sel   = chan;
            res.pos   = song_pos;
            made      = 1'b1;
            ticks_sent++;
        end
    endtask

    function automatic void add_row(input tsq_pkg::op_t op, input int idx,
                                    input logic [tsq_pkg::PERIOD_W-1:0] p1,
                                    input logic [tsq_pkg::PERIOD_W-1:0] p2,
                                    input logic [tsq_pkg::PERIOD_W-1:0] p3,
                                    input logic [tsq_pkg::PERIOD_W-1:0] p4,
                                    input logic g1, input logic g2, input bit typed,
                                    input logic lvl, input logic [1:0] chan,
                                    input logic [tsq_pkg::POS_W-1:0] pos);
        stim_row_t r;
        r.item.op    = op;
        r.item.idx   = idx[tsq_pkg::POS_W-1:0];
        r.item.per   = {p4, p3, p2, p1};
        r.item.g1    = g1;
        r.item.g2    = g2;
        r.typed      = typed;
        r.want.level = lvl;
        r.want.sel   = chan;
        r.want.pos   = pos;
        directed_rows.push_back(r);
    endfunction

    // Mostly short periods so channels toggle often, plus the extremes and full range
    function automatic logic [tsq_pkg::PERIOD_W-1:0] pick_period();
        logic [tsq_pkg::PERIOD_W-1:0] p;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: p = 16'($urandom_range(0, 12));
            5:             p = '0;
            6:             p = '1;
            7:             p = 16'h8000;
            default:       p = 16'($urandom);
        endcase
        return p;
    endfunction

    // Pick the next random item; never tick at an entry that was never written
    function automatic tone_item_t make_item();
        tone_item_t  it;
        int unsigned span;
        int unsigned pick;
        int          c;
        span = 32'(cfg_song_len);
        if (span == 0)
            span = 1;
        else if (span > 256)
            span = 256;
        it.op  = tsq_pkg::OP_TICK;
        it.idx = 8'($urandom_range(0, 255));
        for (c = 0; c < tsq_pkg::CHANNELS; c++)
            it.per[c] = pick_period();
        it.g1 = 1'($urandom_range(0, 1));
        it.g2 = 1'($urandom_range(0, 1));
        pick  = $urandom_range(0, 99);
        if (!entry_written[song_pos])
        begin
            it.op  = tsq_pkg::OP_WRITE;
            it.idx = song_pos;
        end
        else if (pick < 15)
        begin
            it.op = tsq_pkg::OP_WRITE;
            // land most writes on the entries about to play, some inside the song
            if (pick < 8)
                it.idx = song_pos + 8'($urandom_range(0, 2));
            else if (pick < 11)
                it.idx = 8'($urandom_range(0, span - 1));
        end
        return it;
    endfunction

    // Offer one item, hold it until taken, then predict its result
    task automatic send_item(input tone_item_t it, input bit typed,
                             input tsq_pkg::result_t want);
        bit               made;
        tsq_pkg::result_t predicted;
        while (sender_idle_pct != 0 && $urandom_range(0, 99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        operation    <= it.op;
        entry_index  <= it.idx;
        period_one   <= it.per[0];
        period_two   <= it.per[1];
        period_three <= it.per[2];
        period_four  <= it.per[3];
        gate_one     <= it.g1;
        gate_two     <= it.g2;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        advance_song(it, made, predicted);
        if (made)
            tone_results_due.push_back(typed ? want : predicted);
    endtask

    // Drop valid and wait until every predicted result has come back
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (tone_results_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_PAD) @(posedge clk);
    endtask

    // Write one register; the caller drops cfg_valid after its last write
    task automatic write_register(input tsq_pkg::cfg_reg_t idx,
                                  input logic [tsq_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        if (idx == tsq_pkg::CFG_SONG_LENGTH)
            cfg_song_len = data[tsq_pkg::LENGTH_W-1:0];
        else
            cfg_note_ticks = data[tsq_pkg::TICKS_W-1:0];
    endtask

    // Main stimulus
    initial
    begin : stimulus
        tone_item_t                      it;
        tsq_pkg::result_t                no_result;
        int                              ph;
        int                              n;
        int                              n_items;
        int                              c;
        logic [tsq_pkg::CFG_DATA_W-1:0]  len_word;
        logic [tsq_pkg::CFG_DATA_W-1:0]  ticks_word;

        rst_n        = 1'b0;
        in_valid     = 1'b0;
        operation    = tsq_pkg::OP_TICK;
        entry_index  = '0;
        period_one   = '0;
        period_two   = '0;
        period_three = '0;
        period_four  = '0;
        gate_one     = 1'b0;
        gate_two     = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = tsq_pkg::CFG_SONG_LENGTH;
        cfg_data     = '0;
        no_result    = '0;

        for (c = 0; c < tsq_pkg::CHANNELS; c++)
            chan_phase[c] = '0;
        chan_level     = '0;
        song_pos       = '0;
        dur_count      = '0;
        cfg_song_len   = tsq_pkg::SONG_LENGTH_RESET;
        cfg_note_ticks = tsq_pkg::NOTE_TICKS_RESET;

        // After reset: all periods 1 toggle every second tick, output walks channels 4,3,2,1
        add_row(ROW_WR, 0,   16'h0001, 16'h0001, 16'h0001, 16'h0001, 1, 1, 0, 0, 2'd0, 0);
        add_row(ROW_TK, 0,   16'h0000, 16'h0000, 16'h0000, 16'h0000, 0, 0, 1, 0, 2'd3, 0);
        add_row(ROW_TK, 0,   16'h0000, 16'h0000, 16'h0000, 16'h0000, 0, 0, 1, 1, 2'd2, 0);
        add_row(ROW_TK, 0,   16'h0000, 16'h0000, 16'h0000, 16'h0000, 0, 0, 1, 1, 2'd1, 0);
        add_row(ROW_TK, 0,   16'h0000, 16'h0000, 16'h0000, 16'h0000, 0, 0, 1, 0, 2'd0, 0);
        // Overwrite the playing entry with zeros: nothing is gated, levels stay low
        add_row(ROW_WR, 0,   16'h0000, 16'h0000, 16'h0000, 16'h0000, 0, 0, 0, 0, 2'd0, 0);
        add_row(ROW_TK, 0,   16'h0000, 16'h0000, 16'h0000, 16'h0000, 0, 0, 1, 0, 2'd3, 0);
        add_row(ROW_TK, 0,   16'h0000, 16'h0000, 16'h0000, 16'h0000, 0, 0, 1, 0, 2'd1, 0);
        // Top entry, all ones
        add_row(ROW_WR, 255, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 1, 0, 0, 2'd0, 0);
        add_row(ROW_WR, 0,   16'hFFFF, 16'h0000, 16'h8000, 16'h0001, 1, 0, 0, 0, 2'd0, 0);
        add_row(ROW_TK, 0,   16'h0000, 16'h0000, 16'h0000, 16'h0000, 0, 0, 0, 0, 2'd0, 0);
        add_row(ROW_TK, 0,   16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 1, 0, 0, 2'd0, 0);
        add_row(ROW_WR, 1,   16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 0, 1, 0, 0, 2'd0, 0);
        add_row(ROW_WR, 0,   16'h0002, 16'h0003, 16'h0004, 16'h0005, 1, 1, 0, 0, 2'd0, 0);
        for (c = 0; c < 6; c++)
            add_row(ROW_TK, 0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 0, 0, 0, 0, 2'd0, 0);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (ph = 0; ph < NUM_PHASES; ph++)
        begin
            // Load a new setting while the block is idle
            if (ph > 0)
            begin
                case (ph)
                    1:
                    begin
                        len_word   = 16'd1;
                        ticks_word = 16'd0;
                    end
                    2:
                    begin
                        len_word   = 16'd256;
                        ticks_word = 16'd0;
                    end
                    3:
                    begin
                        len_word   = 16'd0;
                        ticks_word = 16'd3;
                    end
                    4:
                    begin
                        len_word   = 16'hFFFF;
                        ticks_word = 16'd2;
                    end
                    5:
                    begin
                        len_word   = 16'd5;
                        ticks_word = 16'hFFFF;
                    end
                    default:
                    begin
                        len_word   = 16'($urandom_range(1, 256));
                        ticks_word = 16'($urandom_range(0, 7));
                    end
                endcase
                write_register(tsq_pkg::CFG_SONG_LENGTH, len_word);
                write_register(tsq_pkg::CFG_NOTE_TICKS, ticks_word);
                cfg_valid <= 1'b0;
            end

            if (ph < 3)
            begin
                sender_idle_pct = 23;
                recv_idle_pct   = 56;
            end
            else if (ph < 5)
            begin
                sender_idle_pct = 56;
                recv_idle_pct   = 23;
            end
            else
            begin
                sender_idle_pct = 0;
                recv_idle_pct   = 0;
            end

            if (ph == 0)
            begin
                foreach (directed_rows[i])
                    send_item(directed_rows[i].item, directed_rows[i].typed,
                              directed_rows[i].want);
            end

            // Hold the receiver off while items keep coming
            if (ph == 5)
                hold_request = 1'b1;

            // Phase 2 runs long enough to walk the whole table and wrap
            n_items = (ph == 2) ? 620 : 45;
            for (n = 0; n < n_items; n++)
            begin
                if (ph == 2 && n == 300)
                    wait_drained();
                it = make_item();
                send_item(it, 1'b0, no_result);
            end
            wait_drained();
        end

        repeat (END_PAD) @(posedge clk);
        $display("Sent %0d items (%0d ticks, %0d entry writes) over %0d register settings.",
                 ticks_sent + writes_sent, ticks_sent, writes_sent, NUM_PHASES);
        $display("Checked %0d results, %0d mismatches.", results_checked, fail_count);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Receiver: random stalls, plus one long hold-off on request
    initial
    begin : receiver
        int unsigned held;
        bit          hold_done;
        out_stall = 1'b0;
        hold_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request && !hold_done)
            begin
                out_stall <= 1'b1;
                for (held = 0; held < HOLD_CYCLES; held++)
                    @(posedge clk);
                hold_done = 1'b1;
            end
            out_stall <= (recv_idle_pct != 0) && ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // Compare each taken result with the oldest prediction
    always
    begin : result_check
        tsq_pkg::result_t seen;
        tsq_pkg::result_t want;
        @(posedge clk);
        if (rst_n && out_valid && !out_stall)
        begin
            seen.level = audio_level;
            seen.sel   = selected_channel;
            seen.pos   = note_position;
            @(negedge clk);
            if (tone_results_due.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("cycle %0d: result with none pending: level %0b channel %0d pos %0d",
                             cycle_count, seen.level, seen.sel, seen.pos);
            end
            else
            begin
                want = tone_results_due.pop_front();
                results_checked++;
                if (seen.level !== want.level || seen.sel !== want.sel || seen.pos !== want.pos)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("cycle %0d: mismatch level %0b/%0b channel %0d/%0d pos %0d/%0d %s",
                                 cycle_count, want.level, seen.level, want.sel, seen.sel,
                                 want.pos, seen.pos, "(expected/actual)");
                end
            end
        end
    end

endmodule

[four_channel_square_tone_sequencer_top.f]
rtl/tsq_pkg.sv
rtl/tsq_song_mem.sv
rtl/tsq_tone_core.sv
rtl/tsq_out_buf.sv
rtl/four_channel_square_tone_sequencer_top.sv
bench/four_channel_square_tone_sequencer_top_tb.sv
